// ===== rtl/vss_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package vss_pkg;

   localparam int MAX_VOICES = 256;
   localparam int POS_W      = $clog2(MAX_VOICES + 1);

   localparam int PRIO_W    = 14;
   localparam int COUNT_W   = 9;
   localparam int INDEX_W   = 8;
   localparam int CAP_W     = 9;
   localparam int VEL_W     = 7;
   localparam int STAGE_W   = 3;
   localparam int ATTEN_W   = 11;
   localparam int COUNT_MAX = (1 << COUNT_W) - 1;

   localparam int DRUM_WEIGHT    = 1000;
   localparam int RELEASE_WEIGHT = 2000;
   localparam int STAGE_WEIGHT   = 200;
   localparam int VEL_SHIFT      = 3;

   // item queue depth must be a power of two
   localparam int ITEM_Q_DEPTH = 4;
   localparam int ITEM_Q_PTR_W = $clog2(ITEM_Q_DEPTH);
   localparam int ITEM_Q_CNT_W = $clog2(ITEM_Q_DEPTH + 1);

   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   localparam logic CSR_IDX_CAP  = 1'b0;
   localparam logic CSR_IDX_AUTO = 1'b1;

   typedef struct packed {
      logic [CAP_W-1:0] voice_limit;
      logic             auto_allocate;
   } cfg_type;

   typedef struct packed {
      logic                     counted;
      logic                     candidate;
      logic signed [PRIO_W-1:0] prio;
      logic [INDEX_W-1:0]       index;
      logic                     last;
   } item_type;

   typedef struct packed {
      logic               steal_valid;
      logic [INDEX_W-1:0] steal_index;
      logic [COUNT_W-1:0] active_count;
   } result_type;

endpackage

`default_nettype wire

// ===== rtl/vss_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module vss_front (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        accept,
   input  wire logic                        voice_active,
   input  wire logic                        percussion,
   input  wire logic                        in_release,
   input  wire logic [vss_pkg::VEL_W-1:0]   velocity,
   input  wire logic [vss_pkg::STAGE_W-1:0] envelope_stage,
   input  wire logic [vss_pkg::ATTEN_W-1:0] atten_level,
   input  wire logic                        spared,
   input  wire logic                        last,
   output vss_pkg::item_type                item
);
   import vss_pkg::*;

   logic [POS_W-1:0]  pos_ff;
   logic [POS_W-1:0]  pos_in;
   logic              in_range;
   logic [PRIO_W-1:0] plus_sum;
   logic [PRIO_W-1:0] minus_sum;

   assign in_range = pos_ff < POS_W'(MAX_VOICES);

   always_comb begin
      plus_sum = (percussion ? PRIO_W'(DRUM_WEIGHT) : '0)
               + (PRIO_W'(velocity) << VEL_SHIFT);
      minus_sum = (in_release ? PRIO_W'(RELEASE_WEIGHT) : '0)
                + PRIO_W'(STAGE_WEIGHT) * PRIO_W'(envelope_stage)
                + PRIO_W'(atten_level);
   end

   always_comb begin
      item.counted   = voice_active && in_range;
      item.candidate = voice_active && in_range && !spared;
      item.prio      = signed'(plus_sum - minus_sum);
      item.index     = INDEX_W'(pos_ff);
      item.last      = last;
   end

   // position saturates once past the voice table
   always_comb begin
      pos_in = pos_ff;
      if (accept) begin
         if (last) begin
            pos_in = '0;
         end else if (in_range) begin
            pos_in = pos_ff + POS_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/vss_item_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module vss_item_queue (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push_en,
   input  vss_pkg::item_type push_item,
   output logic            full,
   input  wire logic       pop_en,
   output vss_pkg::item_type pop_item,
   output logic            empty
);
   import vss_pkg::*;

   item_type                entry_ff [ITEM_Q_DEPTH];
   logic [ITEM_Q_PTR_W-1:0] wr_ptr_ff;
   logic [ITEM_Q_PTR_W-1:0] wr_ptr_in;
   logic [ITEM_Q_PTR_W-1:0] rd_ptr_ff;
   logic [ITEM_Q_PTR_W-1:0] rd_ptr_in;
   logic [ITEM_Q_CNT_W-1:0] count_ff;
   logic [ITEM_Q_CNT_W-1:0] count_in;
   logic                    do_push;
   logic                    do_pop;

   assign full     = count_ff == ITEM_Q_CNT_W'(ITEM_Q_DEPTH);
   assign empty    = count_ff == '0;
   assign pop_item = entry_ff[rd_ptr_ff];
   assign do_push  = push_en && !full;
   assign do_pop   = pop_en && !empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + ITEM_Q_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + ITEM_Q_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + ITEM_Q_CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - ITEM_Q_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= ITEM_Q_CNT_W'(ITEM_Q_DEPTH))
      else $error("item queue over depth");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (count_ff != ITEM_Q_CNT_W'(ITEM_Q_DEPTH)) |->
      (ITEM_Q_PTR_W'(wr_ptr_ff - rd_ptr_ff) == ITEM_Q_PTR_W'(count_ff)))
      else $error("item queue pointers disagree with count");

endmodule

`default_nettype wire

// ===== rtl/vss_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module vss_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  vss_pkg::cfg_type       cfg,
   input  vss_pkg::item_type      q_item,
   input  wire logic              q_empty,
   output logic                   q_pop,
   output vss_pkg::result_type    rsp_word,
   output logic                   rsp_none,
   input  wire logic              rsp_take
);
   import vss_pkg::*;

   logic [COUNT_W-1:0]       total_ff;
   logic [COUNT_W-1:0]       total_in;
   logic signed [PRIO_W-1:0] low_ff;
   logic signed [PRIO_W-1:0] low_in;
   logic [INDEX_W-1:0]       low_idx_ff;
   logic [INDEX_W-1:0]       low_idx_in;
   logic                     found_ff;
   logic                     found_in;

   result_type  out_ff [2];
   logic        out_wr_ff;
   logic        out_rd_ff;
   logic [1:0]  out_cnt_ff;
   logic [1:0]  out_cnt_in;
   logic        out_pop;
   logic        out_push;
   logic        room;
   logic        take;

   logic [COUNT_W-1:0] total_nx;
   logic               found_nx;
   logic [INDEX_W-1:0] idx_nx;
   logic               steal;
   result_type         result;

   assign out_pop  = rsp_take && out_cnt_ff != 2'd0;
   assign room     = out_cnt_ff != 2'd2 || out_pop;
   assign take     = !q_empty && room;
   assign q_pop    = take;
   assign out_push = take && q_item.last;
   assign rsp_none = out_cnt_ff == 2'd0;
   assign rsp_word = out_ff[out_rd_ff];

   always_comb begin
      total_nx = total_ff;
      if (q_item.counted && total_ff != COUNT_W'(COUNT_MAX)) begin
         total_nx = total_ff + COUNT_W'(1);
      end
      low_in   = low_ff;
      idx_nx   = low_idx_ff;
      found_nx = found_ff;
      // strictly lower wins, so the earliest voice keeps a tie
      if (q_item.candidate && (!found_ff || q_item.prio < low_ff)) begin
         low_in   = q_item.prio;
         idx_nx   = q_item.index;
         found_nx = 1'b1;
      end

      steal = cfg.voice_limit != '0 && !cfg.auto_allocate
           && COUNT_W'(total_nx) >= COUNT_W'(cfg.voice_limit) && found_nx;
      result.steal_valid  = steal;
      result.steal_index  = steal ? idx_nx : '0;
      result.active_count = total_nx;

      total_in   = total_ff;
      low_idx_in = low_idx_ff;
      found_in   = found_ff;
      if (take) begin
         if (q_item.last) begin
            // close the scan
            total_in   = '0;
            low_in     = '0;
            low_idx_in = '0;
            found_in   = 1'b0;
         end else begin
            total_in   = total_nx;
            low_idx_in = idx_nx;
            found_in   = found_nx;
         end
      end else begin
         low_in = low_ff;
      end

      out_cnt_in = out_cnt_ff;
      if (out_push && !out_pop) begin
         out_cnt_in = out_cnt_ff + 2'd1;
      end else if (out_pop && !out_push) begin
         out_cnt_in = out_cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff   <= '0;
         low_ff     <= '0;
         low_idx_ff <= '0;
         found_ff   <= 1'b0;
         out_wr_ff  <= 1'b0;
         out_rd_ff  <= 1'b0;
         out_cnt_ff <= 2'd0;
      end else begin
         total_ff   <= total_in;
         low_ff     <= low_in;
         low_idx_ff <= low_idx_in;
         found_ff   <= found_in;
         out_cnt_ff <= out_cnt_in;
         if (out_push) begin
            out_wr_ff <= !out_wr_ff;
         end
         if (out_pop) begin
            out_rd_ff <= !out_rd_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (out_push) begin
         out_ff[out_wr_ff] <= result;
      end
   end

   a_out_bound: assert property (@(posedge clock) disable iff (reset)
      out_cnt_ff != 2'd3)
      else $error("result buffer over depth");

   a_result_shown: assert property (@(posedge clock) disable iff (reset)
      out_push |=> !rsp_none)
      else $error("closed scan left no result word");

   a_scan_cleared: assert property (@(posedge clock) disable iff (reset)
      out_push |=> (total_ff == '0 && !found_ff))
      else $error("scan state not cleared after last record");

endmodule

`default_nettype wire

// ===== rtl/voice_steal_selector.sv =====
// Voice steal selector.
// Input side is a queue: present one voice record on the req_ fields and raise
// push while full is low. Records come in scan order, one voice slot each, and
// the record with req_last high closes the scan.
// Result side is a queue: while empty is low the rsp_ fields hold one word per
// closed scan (steal request, index of the lowest-priority unspared active
// voice or zero without a steal, active count); raise pop to take it.
// Throughput is one record per cycle while full is low. After the closing record
// is accepted, its edge writes it into the four-deep record queue; once the result
// buffer has room, a later edge moves it through the scan unit into the two-deep
// result buffer, where the result word shows up.
// If pop stays low the result buffer fills, the scan unit stops draining the
// record queue, and full rises once four records wait; nothing is dropped.
// Reset clears the scan, both queues, voice_limit and auto_allocate.
// Registers on the APB port: voice_limit at byte 0, auto_allocate at byte 4.
// Write them only while no scan is in flight.
`timescale 1ns / 1ps
`default_nettype none

module voice_steal_selector (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           push,
   output logic                                full,
   input  wire logic                           req_voice_active,
   input  wire logic                           req_percussion,
   input  wire logic                           req_in_release,
   input  wire logic [vss_pkg::VEL_W-1:0]      req_velocity,
   input  wire logic [vss_pkg::STAGE_W-1:0]    req_envelope_stage,
   input  wire logic [vss_pkg::ATTEN_W-1:0]    req_atten_level,
   input  wire logic                           req_spared,
   input  wire logic                           req_last,
   output logic                                empty,
   input  wire logic                           pop,
   output logic                                rsp_steal_valid,
   output logic [vss_pkg::INDEX_W-1:0]         rsp_steal_index,
   output logic [vss_pkg::COUNT_W-1:0]         rsp_active_count,
   input  wire logic                           psel,
   input  wire logic                           penable,
   input  wire logic                           pwrite,
   input  wire logic [vss_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic [vss_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [vss_pkg::CSR_DATA_W-1:0]      prdata,
   output logic                                pready
);
   import vss_pkg::*;

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   item_type   front_item;
   item_type   q_item;
   result_type rsp_word;
   logic       q_full;
   logic       q_empty;
   logic       q_pop;
   logic       accept;
   logic       csr_wr;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && pready;

   always_comb begin
      cfg_in = cfg_ff;
      prdata = '0;
      unique case (paddr[2])
         CSR_IDX_CAP: begin
            prdata = CSR_DATA_W'(cfg_ff.voice_limit);
            if (csr_wr) begin
               cfg_in.voice_limit = pwdata[CAP_W-1:0];
            end
         end
         CSR_IDX_AUTO: begin
            prdata = CSR_DATA_W'(cfg_ff.auto_allocate);
            if (csr_wr) begin
               cfg_in.auto_allocate = pwdata[0];
            end
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign full   = q_full;
   assign accept = push && !q_full;

   vss_front u_front (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .voice_active   (req_voice_active),
      .percussion     (req_percussion),
      .in_release     (req_in_release),
      .velocity       (req_velocity),
      .envelope_stage (req_envelope_stage),
      .atten_level    (req_atten_level),
      .spared         (req_spared),
      .last           (req_last),
      .item           (front_item)
   );

   vss_item_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_en   (accept),
      .push_item (front_item),
      .full      (q_full),
      .pop_en    (q_pop),
      .pop_item  (q_item),
      .empty     (q_empty)
   );

   vss_back u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .q_item   (q_item),
      .q_empty  (q_empty),
      .q_pop    (q_pop),
      .rsp_word (rsp_word),
      .rsp_none (empty),
      .rsp_take (pop)
   );

   assign rsp_steal_valid  = rsp_word.steal_valid;
   assign rsp_steal_index  = rsp_word.steal_index;
   assign rsp_active_count = rsp_word.active_count;

endmodule

`default_nettype wire

// ===== sim/steal_check.sv =====
`timescale 1ns / 1ps

module steal_check (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   input  logic                           full,
   input  logic                           req_voice_active,
   input  logic                           req_percussion,
   input  logic                           req_in_release,
   input  logic [vss_pkg::VEL_W-1:0]      req_velocity,
   input  logic [vss_pkg::STAGE_W-1:0]    req_envelope_stage,
   input  logic [vss_pkg::ATTEN_W-1:0]    req_atten_level,
   input  logic                           req_spared,
   input  logic                           req_last,
   input  logic                           empty,
   input  logic                           pop,
   input  logic                           rsp_steal_valid,
   input  logic [vss_pkg::INDEX_W-1:0]    rsp_steal_index,
   input  logic [vss_pkg::COUNT_W-1:0]    rsp_active_count,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [vss_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [vss_pkg::CSR_DATA_W-1:0] pwdata,
   input  logic                           pready,
   output int                             fail_count,
   output int                             pending
);
   import vss_pkg::*;

   // register copies
   logic [CAP_W-1:0]         cap_reg;
   logic                     auto_reg;

   // running scan
   logic [POS_W-1:0]         scan_pos;
   logic [COUNT_W-1:0]       seen_active;
   logic signed [PRIO_W-1:0] lowest_prio;
   logic [INDEX_W-1:0]       lowest_pos;
   logic                     have_candidate;

   result_type               steal_words [$];
   int                       errors_seen = 0;
   int                       words_owed = 0;

   assign fail_count = errors_seen;
   assign pending    = words_owed;

   always @(posedge clock) begin : watch
      result_type want;
      int         prio;
      int         errs;
      errs = 0;
      if (reset) begin
         cap_reg        = '0;
         auto_reg       = 1'b0;
         scan_pos       = '0;
         seen_active    = '0;
         lowest_prio    = '0;
         lowest_pos     = '0;
         have_candidate = 1'b0;
         steal_words.delete();
         words_owed <= 0;
      end else begin
         if (pop && !empty) begin
            if (steal_words.size() == 0) begin
               $error({"result word with none expected: ",
                       "steal_valid %0d steal_index %0d active_count %0d"},
                      rsp_steal_valid, rsp_steal_index, rsp_active_count);
               errs++;
            end else begin
               want = steal_words.pop_front();
               if (rsp_steal_valid !== want.steal_valid) begin
                  $error("steal_valid: expected %0d, got %0d", want.steal_valid, rsp_steal_valid);
                  errs++;
               end
               if (rsp_steal_index !== want.steal_index) begin
                  $error("steal_index: expected %0d, got %0d", want.steal_index, rsp_steal_index);
                  errs++;
               end
               if (rsp_active_count !== want.active_count) begin
                  $error("active_count: expected %0d, got %0d", want.active_count,
                         rsp_active_count);
                  errs++;
               end
            end
         end

         if (psel && penable && pwrite && pready) begin
            case (paddr[CSR_ADDR_W-1:2])
               CSR_IDX_CAP:  cap_reg  = pwdata[CAP_W-1:0];
               CSR_IDX_AUTO: auto_reg = pwdata[0];
               default: ;
            endcase
         end

         if (push && !full) begin
            // slots past the voice table are neither counted nor ranked
            if (scan_pos < MAX_VOICES && req_voice_active) begin
               if (seen_active != COUNT_MAX) seen_active++;
               if (!req_spared) begin
                  prio = 8 * int'(req_velocity) - STAGE_WEIGHT * int'(req_envelope_stage)
                         - int'(req_atten_level);
                  if (req_percussion) prio += DRUM_WEIGHT;
                  if (req_in_release) prio -= RELEASE_WEIGHT;
                  // strictly lower only, so the earliest of equals holds
                  if (!have_candidate || prio < int'(lowest_prio)) begin
                     lowest_prio    = prio[PRIO_W-1:0];
                     lowest_pos     = scan_pos[INDEX_W-1:0];
                     have_candidate = 1'b1;
                  end
               end
            end
            if (scan_pos != '1) scan_pos++;

            if (req_last) begin
               want.steal_valid  = cap_reg != 0 && !auto_reg && seen_active >= cap_reg &&
                                   have_candidate;
               want.steal_index  = want.steal_valid ? lowest_pos : '0;
               want.active_count = seen_active;
               steal_words.push_back(want);
               scan_pos       = '0;
               seen_active    = '0;
               lowest_prio    = '0;
               lowest_pos     = '0;
               have_candidate = 1'b0;
            end
         end
         words_owed <= steal_words.size();
      end
      errors_seen <= errors_seen + errs;
   end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
   import vss_pkg::*;

   localparam int CYCLE_LIMIT      = 200000;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int SETTLE_CYCLES    = 4;
   localparam int PHASES           = 10;
   localparam int PHASE_RECORDS    = 40;

   typedef struct packed {
      logic               active;
      logic               drum;
      logic               in_release;
      logic [VEL_W-1:0]   velocity;
      logic [STAGE_W-1:0] stage;
      logic [ATTEN_W-1:0] atten;
      logic               spared;
      logic               last;
   } voice_record_type;

   logic                  clock;
   logic                  reset;
   logic                  push;
   logic                  full;
   logic                  req_voice_active;
   logic                  req_percussion;
   logic                  req_in_release;
   logic [VEL_W-1:0]      req_velocity;
   logic [STAGE_W-1:0]    req_envelope_stage;
   logic [ATTEN_W-1:0]    req_atten_level;
   logic                  req_spared;
   logic                  req_last;
   logic                  empty;
   logic                  pop;
   logic                  rsp_steal_valid;
   logic [INDEX_W-1:0]    rsp_steal_index;
   logic [COUNT_W-1:0]    rsp_active_count;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   int fail_count;
   int pending;
   int cycle_count = 0;
   int words_taken = 0;
   bit long_hold   = 1'b0;
   bit hold_taken  = 1'b0;
   bit send_burst  = 1'b0;
   bit take_burst  = 1'b0;

   int phase_cap  [PHASES] = '{1, 2, 3, 4, 8, 16, 0, 5, 256, 511};
   bit phase_auto [PHASES] = '{0, 0, 1, 0, 0, 1, 0, 0, 0, 0};

   voice_steal_selector dut (
      .clock              (clock),
      .reset              (reset),
      .push               (push),
      .full               (full),
      .req_voice_active   (req_voice_active),
      .req_percussion     (req_percussion),
      .req_in_release     (req_in_release),
      .req_velocity       (req_velocity),
      .req_envelope_stage (req_envelope_stage),
      .req_atten_level    (req_atten_level),
      .req_spared         (req_spared),
      .req_last           (req_last),
      .empty              (empty),
      .pop                (pop),
      .rsp_steal_valid    (rsp_steal_valid),
      .rsp_steal_index    (rsp_steal_index),
      .rsp_active_count   (rsp_active_count),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .prdata             (prdata),
      .pready             (pready)
   );

   steal_check u_steal_check (
      .clock              (clock),
      .reset              (reset),
      .push               (push),
      .full               (full),
      .req_voice_active   (req_voice_active),
      .req_percussion     (req_percussion),
      .req_in_release     (req_in_release),
      .req_velocity       (req_velocity),
      .req_envelope_stage (req_envelope_stage),
      .req_atten_level    (req_atten_level),
      .req_spared         (req_spared),
      .req_last           (req_last),
      .empty              (empty),
      .pop                (pop),
      .rsp_steal_valid    (rsp_steal_valid),
      .rsp_steal_index    (rsp_steal_index),
      .rsp_active_count   (rsp_active_count),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .pready             (pready),
      .fail_count         (fail_count),
      .pending            (pending)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   function automatic voice_record_type make_rec(input logic active, input logic drum,
                                                 input logic in_release, input int velocity,
                                                 input int stage, input int atten,
                                                 input logic spared, input logic last);
      voice_record_type r;
      r.active     = active;
      r.drum       = drum;
      r.in_release = in_release;
      r.velocity   = velocity[VEL_W-1:0];
      r.stage      = stage[STAGE_W-1:0];
      r.atten      = atten[ATTEN_W-1:0];
      r.spared     = spared;
      r.last       = last;
      return r;
   endfunction

   function automatic voice_record_type random_record(input int active_pct);
      voice_record_type r;
      r.active     = ($urandom_range(0, 99) < active_pct);
      r.drum       = 1'($urandom_range(0, 1));
      r.in_release = 1'($urandom_range(0, 1));
      r.velocity   = VEL_W'($urandom_range(0, 127));
      r.stage      = STAGE_W'($urandom_range(0, 7));
      // mostly in the nominal range, now and then above it
      r.atten      = ATTEN_W'(($urandom_range(0, 9) == 0) ? $urandom_range(1441, 2047)
                                                          : $urandom_range(0, 1440));
      r.spared     = ($urandom_range(0, 99) < 15);
      r.last       = 1'b0;
      return r;
   endfunction

   task automatic apb_write(input logic [CSR_ADDR_W-1:0] addr, input int value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_config(input int cap, input bit auto_on);
      apb_write({CSR_IDX_CAP, 2'b00}, cap);
      apb_write({CSR_IDX_AUTO, 2'b00}, auto_on);
   endtask

   // drop push, then hold until every result word has been taken
   task automatic wait_idle();
      push <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic send_record(input voice_record_type r);
      int gap;
      gap = send_burst ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      push               <= 1'b1;
      req_voice_active   <= r.active;
      req_percussion     <= r.drum;
      req_in_release     <= r.in_release;
      req_velocity       <= r.velocity;
      req_envelope_stage <= r.stage;
      req_atten_level    <= r.atten;
      req_spared         <= r.spared;
      req_last           <= r.last;
      do @(posedge clock); while (full);
   endtask

   task automatic send_scan(input int len, input int active_pct);
      voice_record_type r;
      voice_record_type prev;
      send_burst = ($urandom_range(0, 2) == 0);
      for (int i = 0; i < len; i++) begin
         r = random_record(active_pct);
         // repeat the ranking fields now and then to force a tie
         if (i > 0 && $urandom_range(0, 7) == 0) begin
            r.drum       = prev.drum;
            r.in_release = prev.in_release;
            r.velocity   = prev.velocity;
            r.stage      = prev.stage;
            r.atten      = prev.atten;
         end
         r.last = (i == len - 1);
         send_record(r);
         prev = r;
      end
   endtask

   // result side
   initial begin : drain
      int gap;
      pop = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         gap = take_burst ? 0 : $urandom_range(0, 10);
         if (long_hold && !hold_taken) begin
            gap        = LONG_HOLD_CYCLES;
            hold_taken = 1'b1;
         end
         if (gap > 0) begin
            pop <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         pop <= 1'b1;
         do @(posedge clock); while (empty);
         words_taken++;
         if (words_taken % 16 == 0) take_burst = ($urandom_range(0, 2) == 0);
      end
   end

   initial begin : stimulus
      int len;
      int sent;
      reset              = 1'b1;
      push               = 1'b0;
      req_voice_active   = 1'b0;
      req_percussion     = 1'b0;
      req_in_release     = 1'b0;
      req_velocity       = '0;
      req_envelope_stage = '0;
      req_atten_level    = '0;
      req_spared         = 1'b0;
      req_last           = 1'b0;
      psel               = 1'b0;
      penable            = 1'b0;
      pwrite             = 1'b0;
      paddr              = '0;
      pwdata             = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // cap zero after reset: never steal
      send_record(make_rec(1, 0, 0, 64, 2, 100, 0, 1));
      wait_idle();

      set_config(2, 0);
      // highest and lowest priority, a spared and an inactive slot at the
      // lowest value, then a tie with the earlier candidate
      send_record(make_rec(1, 1, 0, 127, 0, 0, 0, 0));
      send_record(make_rec(1, 0, 1, 0, 7, 2047, 0, 0));
      send_record(make_rec(1, 0, 1, 0, 7, 2047, 1, 0));
      send_record(make_rec(0, 0, 1, 0, 7, 2047, 0, 0));
      send_record(make_rec(1, 0, 1, 0, 7, 2047, 0, 1));
      // equal priorities: first one wins
      send_record(make_rec(1, 0, 0, 10, 1, 5, 0, 0));
      send_record(make_rec(1, 0, 0, 10, 1, 5, 0, 1));
      // all active voices spared: no candidate
      send_record(make_rec(1, 1, 1, 99, 3, 700, 1, 0));
      send_record(make_rec(1, 1, 1, 99, 3, 700, 1, 0));
      send_record(make_rec(1, 0, 0, 0, 0, 1440, 1, 1));
      // below the cap
      send_record(make_rec(1, 0, 0, 33, 4, 1440, 0, 1));
      // nothing active
      send_record(make_rec(0, 1, 1, 127, 7, 2047, 0, 1));
      wait_idle();

      set_config(1, 1);
      send_record(make_rec(1, 0, 1, 5, 6, 300, 0, 0));
      send_record(make_rec(1, 1, 0, 120, 1, 20, 0, 1));
      wait_idle();

      set_config(1, 0);
      send_record(make_rec(1, 0, 1, 5, 6, 300, 0, 0));
      send_record(make_rec(1, 1, 0, 120, 1, 20, 0, 1));
      wait_idle();

      for (int p = 0; p < PHASES; p++) begin
         set_config(phase_cap[p], phase_auto[p]);
         // stall the result side while short scans keep coming
         if (p == 0) long_hold = 1'b1;
         // scans that run past the voice table
         if (phase_cap[p] == MAX_VOICES) send_scan(MAX_VOICES + 14, 100);
         if (phase_cap[p] == COUNT_MAX) send_scan(COUNT_MAX + 9, 90);
         sent = 0;
         while (sent < PHASE_RECORDS) begin
            len = $urandom_range(1, (phase_cap[p] > 16) ? 20 : phase_cap[p] + 4);
            send_scan(len, 85);
            sent += len;
         end
         wait_idle();
      end

      repeat (10) @(posedge clock);
      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/vss_pkg.sv
rtl/vss_front.sv
rtl/vss_item_queue.sv
rtl/vss_back.sv
rtl/voice_steal_selector.sv
sim/steal_check.sv
sim/tb_top.sv
